### rtl/pdh_pkg.sv
package pdh_pkg;

    localparam int CUTOFF_W = 50;
    localparam int WIDTH_W  = 24;
    localparam int CNT_W    = 32;
    localparam int IDX_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_PAIR_BINS    = 256;
    localparam int DEF_DENSITY_BINS = 256;
    localparam int DEF_COORD_BITS   = 24;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 24'd4096;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_SQ     = 2'd0,
        CFG_PAIR_WIDTH    = 2'd1,
        CFG_DENSITY_WIDTH = 2'd2,
        CFG_DENSITY_EN    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FUNC_PAIR      = 2'd0,
        FUNC_DENSITY   = 2'd1,
        FUNC_READ_PAIR = 2'd2,
        FUNC_READ_DENS = 2'd3
    } func_t;

endpackage

### rtl/pdh_ram.sv
module pdh_ram #(
    parameter int DEPTH = pdh_pkg::DEF_PAIR_BINS
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [pdh_pkg::CNT_W-1:0]  wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [pdh_pkg::CNT_W-1:0]  rdata
);

    logic [pdh_pkg::CNT_W-1:0] mem [DEPTH];
    logic [pdh_pkg::CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pdh_isqrt.sv
module pdh_isqrt #(
    parameter int RW = pdh_pkg::DEF_COORD_BITS + 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] operand,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] n_reg;
    logic [RW+2:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;

    // one root bit per cycle, two operand bits shifted in
    assign rem_sh = {rem_reg[RW:0], n_reg[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[2*RW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/pdh_div.sv
module pdh_div #(
    parameter int NW = pdh_pkg::DEF_COORD_BITS + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NW-1:0]               dividend,
    input  logic [pdh_pkg::WIDTH_W-1:0] divisor,
    output logic                        done,
    output logic [NW-1:0]               quot
);

    localparam int DW = pdh_pkg::WIDTH_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] d_reg;
    logic [DW:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg[DW-1:0], q_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_reg <= rem_sh - {1'b0, d_reg};
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### rtl/pair_distance_histogram.sv
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   func ax ay az bx by bz read_index
// out      output     out_valid/out_stall bin_index counted out_of_range bin_count
// cfg      input      cfg_we              cfg_index cfg_wdata
//
// one item at a time: pair samples pass through the bit-serial square root and divider,
// density samples through the divider at most, and reads through neither.
// after reset a clearing pass over max(PAIR_BINS, DENSITY_BINS) addresses zeroes both
// histograms while in_stall stays high. a finished result waits in the output
// register under out_stall while the next item is taken.
module pair_distance_histogram #(
    parameter int PAIR_BINS    = pdh_pkg::DEF_PAIR_BINS,
    parameter int DENSITY_BINS = pdh_pkg::DEF_DENSITY_BINS,
    parameter int COORD_BITS   = pdh_pkg::DEF_COORD_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdh_pkg::CUTOFF_W-1:0]     cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       func,
    input  logic signed [COORD_BITS-1:0]     ax,
    input  logic signed [COORD_BITS-1:0]     ay,
    input  logic signed [COORD_BITS-1:0]     az,
    input  logic signed [COORD_BITS-1:0]     bx,
    input  logic signed [COORD_BITS-1:0]     by,
    input  logic signed [COORD_BITS-1:0]     bz,
    input  logic [pdh_pkg::IDX_W-1:0]        read_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pdh_pkg::IDX_W-1:0]        bin_index,
    output logic                             counted,
    output logic                             out_of_range,
    output logic [pdh_pkg::CNT_W-1:0]        bin_count
);

    localparam int AW   = COORD_BITS + 1;
    localparam int SQW  = 2 * AW;
    localparam int D2W  = 2 * COORD_BITS + 4;
    localparam int RW   = COORD_BITS + 2;
    localparam int CMPW = (D2W > pdh_pkg::CUTOFF_W) ? D2W : pdh_pkg::CUTOFF_W;
    localparam int PAW  = $clog2(PAIR_BINS);
    localparam int DAW  = $clog2(DENSITY_BINS);
    localparam int MAXB = (PAIR_BINS > DENSITY_BINS) ? PAIR_BINS : DENSITY_BINS;
    localparam int CLW  = $clog2(MAXB);
    localparam int MAW  = (PAW > DAW) ? PAW : DAW;
    localparam int CW   = pdh_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SQ, S_CMP, S_SQRT, S_DIV, S_READ, S_UPD, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [pdh_pkg::CUTOFF_W-1:0] cutoff_reg;
    logic [pdh_pkg::WIDTH_W-1:0]  pw_reg;
    logic [pdh_pkg::WIDTH_W-1:0]  dw_reg;
    logic                         den_reg;

    logic [AW-1:0]  abs_reg [3];
    logic [1:0]     sq_cnt_reg;
    logic [D2W-1:0] d2_reg;
    logic           dens_sel_reg;
    logic           is_read_reg;
    logic [MAW-1:0] addr_reg;
    logic [CLW-1:0] clr_cnt_reg;

    logic [pdh_pkg::IDX_W-1:0] res_idx_reg;
    logic                      res_cnt_reg;
    logic                      res_oor_reg;
    logic [CW-1:0]             res_count_reg;

    logic                      out_valid_reg;
    logic [pdh_pkg::IDX_W-1:0] out_idx_reg;
    logic                      out_cnt_reg;
    logic                      out_oor_reg;
    logic [CW-1:0]             out_count_reg;

    logic          in_xfer;
    logic [AW-1:0] sel_abs;
    logic [SQW-1:0] sq;
    logic          sqrt_start, sqrt_done;
    logic [RW-1:0] root;
    logic          div_start, div_done;
    logic [RW-1:0] div_n, quot;
    logic [pdh_pkg::WIDTH_W-1:0] div_d;
    logic          pair_we, dens_we;
    logic [PAW-1:0] pair_waddr;
    logic [DAW-1:0] dens_waddr;
    logic [CW-1:0]  wdata;
    logic [CW-1:0]  pair_rdata, dens_rdata, rdata;
    logic [CW-1:0]  bumped;
    logic           emit_load;

    function automatic logic [AW-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
        logic signed [AW-1:0] d;
        d = AW'(a) - AW'(b);
        return d[AW-1] ? AW'(-d) : AW'(d);
    endfunction

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
            pw_reg     <= pdh_pkg::WIDTH_RESET;
            dw_reg     <= pdh_pkg::WIDTH_RESET;
            den_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (pdh_pkg::cfg_idx_t'(cfg_index))
                pdh_pkg::CFG_CUTOFF_SQ:     cutoff_reg <= cfg_wdata;
                pdh_pkg::CFG_PAIR_WIDTH:    pw_reg <= cfg_wdata[pdh_pkg::WIDTH_W-1:0];
                pdh_pkg::CFG_DENSITY_WIDTH: dw_reg <= cfg_wdata[pdh_pkg::WIDTH_W-1:0];
                pdh_pkg::CFG_DENSITY_EN:    den_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // one square per cycle accumulated into d2
    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sel_abs = abs_reg[0];
            2'd1:    sel_abs = abs_reg[1];
            default: sel_abs = abs_reg[2];
        endcase
    end
    assign sq = SQW'(sel_abs) * SQW'(sel_abs);

    assign sqrt_start = (state_reg == S_CMP) && (CMPW'(d2_reg) < CMPW'(cutoff_reg))
                        && (pw_reg != '0);

    pdh_isqrt #(.RW(RW)) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (d2_reg),
        .done    (sqrt_done),
        .root    (root)
    );

    always_comb
    begin
        div_start = 1'b0;
        div_n     = root;
        div_d     = pw_reg;
        if (state_reg == S_IDLE)
        begin
            div_n     = RW'(unsigned'(ax));
            div_d     = dw_reg;
            div_start = in_xfer && (pdh_pkg::func_t'(func) == pdh_pkg::FUNC_DENSITY)
                        && den_reg && (dw_reg != '0) && !ax[COORD_BITS-1];
        end
        else if (state_reg == S_SQRT)
        begin
            div_start = sqrt_done;
        end
    end

    pdh_div #(.NW(RW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (quot)
    );

    assign rdata  = dens_sel_reg ? dens_rdata : pair_rdata;
    assign bumped = (rdata == pdh_pkg::CNT_MAX) ? rdata : rdata + 1'b1;

    always_comb
    begin
        pair_we    = 1'b0;
        dens_we    = 1'b0;
        pair_waddr = addr_reg[PAW-1:0];
        dens_waddr = addr_reg[DAW-1:0];
        wdata      = bumped;
        if (state_reg == S_CLEAR)
        begin
            pair_we    = (32'(clr_cnt_reg) < 32'(PAIR_BINS));
            dens_we    = (32'(clr_cnt_reg) < 32'(DENSITY_BINS));
            pair_waddr = PAW'(clr_cnt_reg);
            dens_waddr = DAW'(clr_cnt_reg);
            wdata      = '0;
        end
        else if (state_reg == S_UPD && !is_read_reg)
        begin
            pair_we = !dens_sel_reg;
            dens_we = dens_sel_reg;
        end
    end

    pdh_ram #(.DEPTH(PAIR_BINS)) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (wdata),
        .raddr (addr_reg[PAW-1:0]),
        .rdata (pair_rdata)
    );

    pdh_ram #(.DEPTH(DENSITY_BINS)) u_dens_ram (
        .clk   (clk),
        .we    (dens_we),
        .waddr (dens_waddr),
        .wdata (wdata),
        .raddr (addr_reg[DAW-1:0]),
        .rdata (dens_rdata)
    );

    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_cnt_reg == CLW'(MAXB - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (pdh_pkg::func_t'(func))
                        pdh_pkg::FUNC_PAIR:    state_next = S_SQ;
                        pdh_pkg::FUNC_DENSITY: state_next = div_start ? S_DIV : S_EMIT;
                        pdh_pkg::FUNC_READ_PAIR:
                            state_next = (32'(read_index) < 32'(PAIR_BINS)) ? S_READ : S_EMIT;
                        default:
                            state_next = (32'(read_index) < 32'(DENSITY_BINS)) ? S_READ : S_EMIT;
                    endcase
                end
            end
            S_SQ:   if (sq_cnt_reg == 2'd2) state_next = S_CMP;
            S_CMP:  state_next = sqrt_start ? S_SQRT : S_EMIT;
            S_SQRT: if (sqrt_done) state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = (32'(quot) < 32'(dens_sel_reg ? DENSITY_BINS : PAIR_BINS))
                                 ? S_READ : S_EMIT;
                end
            end
            S_READ: state_next = S_UPD;
            S_UPD:  state_next = S_EMIT;
            S_EMIT: if (emit_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == S_SQ)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            else
            begin
                sq_cnt_reg <= '0;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            abs_reg[0]    <= abs_diff(ax, bx);
            abs_reg[1]    <= abs_diff(ay, by);
            abs_reg[2]    <= abs_diff(az, bz);
            d2_reg        <= '0;
            dens_sel_reg  <= (pdh_pkg::func_t'(func) == pdh_pkg::FUNC_DENSITY)
                             || (pdh_pkg::func_t'(func) == pdh_pkg::FUNC_READ_DENS);
            is_read_reg   <= func[1];
            addr_reg      <= MAW'(read_index);
            res_idx_reg   <= func[1] ? read_index : '0;
            res_cnt_reg   <= 1'b0;
            res_count_reg <= '0;
            case (pdh_pkg::func_t'(func))
                pdh_pkg::FUNC_PAIR:      res_oor_reg <= 1'b0;
                pdh_pkg::FUNC_DENSITY:   res_oor_reg <= den_reg &&
                                             ((dw_reg == '0) || ax[COORD_BITS-1]);
                pdh_pkg::FUNC_READ_PAIR: res_oor_reg <= !(32'(read_index) < 32'(PAIR_BINS));
                default: res_oor_reg <= !(32'(read_index) < 32'(DENSITY_BINS));
            endcase
        end
        if (state_reg == S_SQ)
        begin
            d2_reg <= d2_reg + D2W'(sq);
        end
        if (state_reg == S_CMP)
        begin
            // below cutoff but zero width is out of range
            res_oor_reg <= (CMPW'(d2_reg) < CMPW'(cutoff_reg)) && (pw_reg == '0);
        end
        if (state_reg == S_DIV && div_done)
        begin
            addr_reg <= MAW'(quot);
            if (32'(quot) < 32'(dens_sel_reg ? DENSITY_BINS : PAIR_BINS))
            begin
                res_idx_reg <= quot[pdh_pkg::IDX_W-1:0];
            end
            else
            begin
                res_oor_reg <= 1'b1;
            end
        end
        if (state_reg == S_UPD)
        begin
            res_cnt_reg   <= !is_read_reg;
            res_count_reg <= is_read_reg ? rdata : bumped;
        end
        if (emit_load)
        begin
            out_idx_reg   <= res_idx_reg;
            out_cnt_reg   <= res_cnt_reg;
            out_oor_reg   <= res_oor_reg;
            out_count_reg <= res_count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bin_index    = out_idx_reg;
    assign counted      = out_cnt_reg;
    assign out_of_range = out_oor_reg;
    assign bin_count    = out_count_reg;

    a_cnt_oor_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(counted && out_of_range))
        else $error("counted and out_of_range both set");

    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && counted |-> bin_count != '0)
        else $error("counted bin reports zero");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pair_we && !dens_we)
        else $error("histogram written while idle");

endmodule
